// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the predictor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define BDP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Implication: antecedent in this cycle, consequent in the next cycle.
`define BDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BDP_ASSERT(label, clk, rst_n, prop)
`define BDP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/bdp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdp_pkg
// Types, constants and helper functions of the branch direction predictor.
// ----------------------------------------------------------------------------
package bdp_pkg;

    localparam int GLOBAL_BITS = 13;
    localparam int LOCAL_BITS  = 11;
    localparam int PC_BITS     = 11;

    localparam int GT_DEPTH = 1 << GLOBAL_BITS;
    localparam int LH_DEPTH = 1 << PC_BITS;
    localparam int LC_DEPTH = 1 << LOCAL_BITS;

    // Predictor type codes
    localparam logic [1:0] PT_STATIC = 2'd0;
    localparam logic [1:0] PT_GSHARE = 2'd1;
    localparam logic [1:0] PT_TOURN  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TYPE  = 2'd0;
    localparam logic [1:0] CFG_GLEN  = 2'd1;
    localparam logic [1:0] CFG_LLEN  = 2'd2;
    localparam logic [1:0] CFG_PCLEN = 2'd3;

    // Input transaction modes
    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_TRAIN   = 1'b1;

    // Counter reset value: weakly not taken / weakly global
    localparam logic [1:0] CTR_WEAK_LOW = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LHT,
        ST_LCT
    } t_state;

    typedef struct packed {
        logic [1:0]             ptype;
        logic [GLOBAL_BITS-1:0] gmask;
        logic [LOCAL_BITS-1:0]  lmask;
        logic [PC_BITS-1:0]     pmask;
    } t_cfg;

    // Global table entry packs {choice counter, global counter}.
    typedef struct packed {
        logic [GLOBAL_BITS-1:0] gt_raddr;
        logic                   gt_we;
        logic [GLOBAL_BITS-1:0] gt_waddr;
        logic [3:0]             gt_wdata;
        logic [PC_BITS-1:0]     lh_raddr;
        logic                   lh_we;
        logic [PC_BITS-1:0]     lh_waddr;
        logic [LOCAL_BITS-1:0]  lh_wdata;
        logic [LOCAL_BITS-1:0]  lc_raddr;
        logic                   lc_we;
        logic [LOCAL_BITS-1:0]  lc_waddr;
        logic [1:0]             lc_wdata;
    } t_mem_req;

    typedef struct packed {
        logic [3:0]            gt_rdata;
        logic [LOCAL_BITS-1:0] lh_rdata;
        logic [1:0]            lc_rdata;
    } t_mem_rsp;

    // Low-bit mask of min(len, cap) ones.
    function automatic logic [15:0] low_mask(input logic [3:0] len, input logic [4:0] cap);
        logic [4:0]  n;
        logic [15:0] m;
        n = ({1'b0, len} > cap) ? cap : {1'b0, len};
        for (int i = 0; i < 16; i++) begin
            m[i] = (5'(i) < n);
        end
        return m;
    endfunction

    // Saturating 2-bit counter step.
    function automatic logic [1:0] bump(input logic [1:0] c, input logic up);
        logic [1:0] r;
        if (up) begin
            r = (c == 2'd3) ? c : c + 2'd1;
        end else begin
            r = (c == 2'd0) ? c : c - 2'd1;
        end
        return r;
    endfunction

endpackage

// ----- rtl/bdp_ram.sv -----
// ----------------------------------------------------------------------------
// bdp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/bdp_store.sv -----
// ----------------------------------------------------------------------------
// bdp_store
// Predictor tables and the clearing sweep that restores their reset values.
// ----------------------------------------------------------------------------
module bdp_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr_start,
    input  bdp_pkg::t_mem_req i_req,
    output bdp_pkg::t_mem_rsp o_rsp,
    output logic              o_busy
);
    import bdp_pkg::*;

    `include "assert_macros.svh"

    logic                   r_busy;
    logic [GLOBAL_BITS-1:0] r_clr_addr;
    logic                   n_busy;
    logic [GLOBAL_BITS-1:0] n_clr_addr;

    logic                   w_gt_we;
    logic [GLOBAL_BITS-1:0] w_gt_waddr;
    logic [3:0]             w_gt_wdata;
    logic                   w_lh_we;
    logic [PC_BITS-1:0]     w_lh_waddr;
    logic [LOCAL_BITS-1:0]  w_lh_wdata;
    logic                   w_lc_we;
    logic [LOCAL_BITS-1:0]  w_lc_waddr;
    logic [1:0]             w_lc_wdata;

    always_comb begin
        n_busy     = r_busy;
        n_clr_addr = r_clr_addr;
        if (i_clr_start) begin
            n_busy     = 1'b1;
            n_clr_addr = '0;
        end else if (r_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == GLOBAL_BITS'(GT_DEPTH - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_busy     <= n_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    // Sweep owns the write ports while it runs; smaller tables wrap over their depth.
    always_comb begin
        if (r_busy) begin
            w_gt_we    = 1'b1;
            w_gt_waddr = r_clr_addr;
            w_gt_wdata = {CTR_WEAK_LOW, CTR_WEAK_LOW};
            w_lh_we    = 1'b1;
            w_lh_waddr = r_clr_addr[PC_BITS-1:0];
            w_lh_wdata = '0;
            w_lc_we    = 1'b1;
            w_lc_waddr = r_clr_addr[LOCAL_BITS-1:0];
            w_lc_wdata = CTR_WEAK_LOW;
        end else begin
            w_gt_we    = i_req.gt_we;
            w_gt_waddr = i_req.gt_waddr;
            w_gt_wdata = i_req.gt_wdata;
            w_lh_we    = i_req.lh_we;
            w_lh_waddr = i_req.lh_waddr;
            w_lh_wdata = i_req.lh_wdata;
            w_lc_we    = i_req.lc_we;
            w_lc_waddr = i_req.lc_waddr;
            w_lc_wdata = i_req.lc_wdata;
        end
    end

    bdp_ram #(.WIDTH(4), .DEPTH(GT_DEPTH)) u_gt_ram (
        .i_clk   (i_clk),
        .i_we    (w_gt_we),
        .i_waddr (w_gt_waddr),
        .i_wdata (w_gt_wdata),
        .i_raddr (i_req.gt_raddr),
        .o_rdata (o_rsp.gt_rdata)
    );

    bdp_ram #(.WIDTH(LOCAL_BITS), .DEPTH(LH_DEPTH)) u_lh_ram (
        .i_clk   (i_clk),
        .i_we    (w_lh_we),
        .i_waddr (w_lh_waddr),
        .i_wdata (w_lh_wdata),
        .i_raddr (i_req.lh_raddr),
        .o_rdata (o_rsp.lh_rdata)
    );

    bdp_ram #(.WIDTH(2), .DEPTH(LC_DEPTH)) u_lc_ram (
        .i_clk   (i_clk),
        .i_we    (w_lc_we),
        .i_waddr (w_lc_waddr),
        .i_wdata (w_lc_wdata),
        .i_raddr (i_req.lc_raddr),
        .o_rdata (o_rsp.lc_rdata)
    );

    assign o_busy = r_busy;

    `BDP_ASSERT(a_no_write_in_sweep, i_clk, i_rst_n,
        !(r_busy && (i_req.gt_we || i_req.lh_we || i_req.lc_we)))
    `BDP_ASSERT_NEXT(a_start_sets_busy, i_clk, i_rst_n, i_clr_start, r_busy && r_clr_addr == '0)
    `BDP_ASSERT_NEXT(a_sweep_advances, i_clk, i_rst_n, r_busy && !i_clr_start,
        r_clr_addr == $past(r_clr_addr) + 1'b1)

endmodule

// ----- rtl/bdp_core.sv -----
// ----------------------------------------------------------------------------
// bdp_core
// Per-transaction sequencer: table reads, prediction, counter and history update.
// ----------------------------------------------------------------------------
module bdp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdp_pkg::t_cfg     i_cfg,
    input  logic              i_cfg_clear,
    input  logic              i_busy,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic [31:0]       i_branch_pc,
    input  logic              i_taken,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_predict_taken,
    output bdp_pkg::t_mem_req o_req,
    input  bdp_pkg::t_mem_rsp i_rsp
);
    import bdp_pkg::*;

    `include "assert_macros.svh"

    t_state                 r_state, n_state;
    logic                   r_mode;
    logic                   r_taken;
    logic [GLOBAL_BITS-1:0] r_gidx;
    logic [PC_BITS-1:0]     r_pidx;
    logic [LOCAL_BITS-1:0]  r_lidx;
    logic [GLOBAL_BITS-1:0] r_gh;
    logic                   r_last_l;
    logic                   r_last_g;
    logic                   r_out_valid;
    logic                   r_out_taken;

    logic                   w_in_acc;
    logic                   w_done;
    logic                   w_train;
    logic [GLOBAL_BITS-1:0] w_gidx;
    logic [PC_BITS-1:0]     w_pidx;
    logic [LOCAL_BITS-1:0]  w_lidx;
    logic [1:0]             w_gctr;
    logic [1:0]             w_cctr;
    logic [1:0]             w_cnew;
    logic                   w_lguess;
    logic                   w_gguess;
    logic                   w_pred;
    logic [GLOBAL_BITS-1:0] w_gh_next;
    logic                   w_gh_upd;

    assign o_in_ready = (r_state == ST_IDLE) && !i_busy;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_done     = (r_state == ST_LCT) &&
                        (r_mode == MODE_TRAIN || !r_out_valid || i_out_ready);
    assign w_train    = (r_state == ST_LCT) && (r_mode == MODE_TRAIN);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_LHT;
                end
            end
            ST_LHT: begin
                n_state = ST_LCT;
            end
            ST_LCT: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Index and prediction datapath
    always_comb begin
        if (i_cfg.ptype == PT_GSHARE) begin
            w_gidx = (r_gh ^ i_branch_pc[GLOBAL_BITS-1:0]) & i_cfg.gmask;
        end else begin
            w_gidx = r_gh & i_cfg.gmask;
        end
        w_pidx   = i_branch_pc[PC_BITS-1:0] & i_cfg.pmask;
        w_lidx   = i_rsp.lh_rdata & i_cfg.lmask;
        w_gctr   = i_rsp.gt_rdata[1:0];
        w_cctr   = i_rsp.gt_rdata[3:2];
        w_lguess = i_rsp.lc_rdata[1];
        w_gguess = w_gctr[1];
        case (i_cfg.ptype)
            PT_STATIC: w_pred = 1'b1;
            PT_GSHARE: w_pred = w_gguess;
            PT_TOURN:  w_pred = w_cctr[1] ? w_lguess : w_gguess;
            default:   w_pred = 1'b0;
        endcase
        if (r_taken == r_last_l && r_taken != r_last_g) begin
            w_cnew = bump(w_cctr, 1'b1);
        end else if (r_taken != r_last_l && r_taken == r_last_g) begin
            w_cnew = bump(w_cctr, 1'b0);
        end else begin
            w_cnew = w_cctr;
        end
        w_gh_next = {r_gh[GLOBAL_BITS-2:0], r_taken} & i_cfg.gmask;
        w_gh_upd  = w_train && (i_cfg.ptype == PT_GSHARE || i_cfg.ptype == PT_TOURN);
    end

    // Memory requests: gt/lh reads track input in idle, lc in ST_LHT, then hold.
    always_comb begin
        o_req          = '0;
        o_req.gt_raddr = (r_state == ST_IDLE) ? w_gidx : r_gidx;
        o_req.lh_raddr = (r_state == ST_IDLE) ? w_pidx : r_pidx;
        o_req.lc_raddr = (r_state == ST_LHT) ? w_lidx : r_lidx;
        o_req.gt_waddr = r_gidx;
        o_req.lh_waddr = r_pidx;
        o_req.lc_waddr = r_lidx;
        o_req.lh_wdata = {i_rsp.lh_rdata[LOCAL_BITS-2:0], r_taken} & i_cfg.lmask;
        o_req.lc_wdata = bump(i_rsp.lc_rdata, r_taken);
        case (i_cfg.ptype)
            PT_GSHARE: begin
                o_req.gt_we    = w_train;
                o_req.gt_wdata = {w_cctr, bump(w_gctr, r_taken)};
            end
            PT_TOURN: begin
                o_req.gt_we    = w_train;
                o_req.gt_wdata = {w_cnew, bump(w_gctr, r_taken)};
                o_req.lh_we    = w_train;
                o_req.lc_we    = w_train;
            end
            default: begin
                o_req.gt_wdata = i_rsp.gt_rdata;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gh        <= '0;
            r_last_l    <= 1'b0;
            r_last_g    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_clear) begin
                r_gh     <= '0;
                r_last_l <= 1'b0;
                r_last_g <= 1'b0;
            end else begin
                if (w_gh_upd) begin
                    r_gh <= w_gh_next;
                end
                if (w_done && r_mode == MODE_PREDICT && i_cfg.ptype == PT_TOURN) begin
                    r_last_l <= w_lguess;
                    r_last_g <= w_gguess;
                end
            end
            if (w_done && r_mode == MODE_PREDICT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_mode  <= i_mode;
            r_taken <= i_taken;
            r_gidx  <= w_gidx;
            r_pidx  <= w_pidx;
        end
        if (r_state == ST_LHT) begin
            r_lidx <= w_lidx;
        end
        if (w_done && r_mode == MODE_PREDICT) begin
            r_out_taken <= w_pred;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_predict_taken = r_out_taken;

    `BDP_ASSERT(a_write_only_on_train, i_clk, i_rst_n,
        !(o_req.gt_we || o_req.lh_we || o_req.lc_we) || w_train)
    `BDP_ASSERT_NEXT(a_accept_starts_read, i_clk, i_rst_n, w_in_acc, r_state == ST_LHT)
    `BDP_ASSERT(a_history_masked, i_clk, i_rst_n, (r_gh & ~i_cfg.gmask) == '0)
    `BDP_ASSERT_NEXT(a_train_no_result, i_clk, i_rst_n, w_train && !r_out_valid, !r_out_valid)

endmodule

// ----- rtl/branch_direction_predictor.sv -----
// Each transaction reads the local history RAM, then the local counter RAM (ST_LHT,
// ST_LCT) before its write-back or registered prediction result; it waits in ST_LCT
// while an earlier result is not taken. No new transaction is accepted until it is
// done. Reset and every configuration write start a clearing sweep over the counter
// and history RAMs; no input transaction is accepted until it ends.
// Reset is synchronous, active low; configuration returns to gshare, 13/10/10 bits.
// ----------------------------------------------------------------------------
// branch_direction_predictor
// Static, gshare and tournament conditional-branch direction predictor.
// ----------------------------------------------------------------------------
module branch_direction_predictor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [31:0] i_branch_pc,
    input  logic        i_taken,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_predict_taken
);
    import bdp_pkg::*;

    logic [1:0]  r_ptype;
    logic [3:0]  r_glen;
    logic [3:0]  r_llen;
    logic [3:0]  r_plen;
    logic [15:0] w_gmask;
    logic [15:0] w_lmask;
    logic [15:0] w_pmask;
    t_cfg        w_cfg;
    t_mem_req    w_req;
    t_mem_rsp    w_rsp;
    logic        w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptype <= PT_GSHARE;
            r_glen  <= 4'd13;
            r_llen  <= 4'd10;
            r_plen  <= 4'd10;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_TYPE:  r_ptype <= i_cfg_wdata[1:0];
                CFG_GLEN:  r_glen  <= i_cfg_wdata;
                CFG_LLEN:  r_llen  <= i_cfg_wdata;
                CFG_PCLEN: r_plen  <= i_cfg_wdata;
                default:   r_ptype <= r_ptype;
            endcase
        end
    end

    assign w_gmask     = low_mask(r_glen, 5'(GLOBAL_BITS));
    assign w_lmask     = low_mask(r_llen, 5'(LOCAL_BITS));
    assign w_pmask     = low_mask(r_plen, 5'(PC_BITS));
    assign w_cfg.ptype = r_ptype;
    assign w_cfg.gmask = w_gmask[GLOBAL_BITS-1:0];
    assign w_cfg.lmask = w_lmask[LOCAL_BITS-1:0];
    assign w_cfg.pmask = w_pmask[PC_BITS-1:0];

    bdp_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr_start (i_cfg_wr_en),
        .i_req       (w_req),
        .o_rsp       (w_rsp),
        .o_busy      (w_busy)
    );

    bdp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cfg_clear     (i_cfg_wr_en),
        .i_busy          (w_busy),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_branch_pc     (i_branch_pc),
        .i_taken         (i_taken),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_predict_taken (o_predict_taken),
        .o_req           (w_req),
        .i_rsp           (w_rsp)
    );

endmodule

// ----- test/branch_direction_predictor_checker.sv -----
// ----------------------------------------------------------------------------
// branch_direction_predictor_checker
// Watches the configuration port and both transaction channels of the
// predictor, keeps its own copy of the counter and history tables, predicts
// the direction of every request and compares it with the returned result.
// ----------------------------------------------------------------------------
module branch_direction_predictor_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_mode,
    input  logic [31:0] i_branch_pc,
    input  logic        i_taken,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_predict_taken,
    output int          o_pending,
    output int          o_errors
);
    import bdp_pkg::*;

    localparam int MAX_PRINTED = 100;

    logic [1:0] cfg_type;
    logic [3:0] cfg_glen;
    logic [3:0] cfg_llen;
    logic [3:0] cfg_pclen;

    logic [GLOBAL_BITS-1:0] ghist;
    logic [1:0]             gctr  [GT_DEPTH];
    logic [1:0]             cctr  [GT_DEPTH];
    logic [LOCAL_BITS-1:0]  lhist [LH_DEPTH];
    logic [1:0]             lctr  [LC_DEPTH];
    logic                   last_local;
    logic                   last_global;

    logic direction_q [$];
    int   err_count;

    // A length beyond the table size acts as the full size.
    function automatic int unsigned len_mask(input logic [3:0] len, input int cap);
        int n;
        n = (int'(len) > cap) ? cap : int'(len);
        return (32'd1 << n) - 32'd1;
    endfunction

    function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
        if (up) begin
            return (c == 2'd3) ? c : c + 2'd1;
        end
        return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    task automatic clear_tables();
        ghist = '0;
        for (int i = 0; i < GT_DEPTH; i++) begin
            gctr[i] = CTR_WEAK_LOW;
            cctr[i] = CTR_WEAK_LOW;
        end
        for (int i = 0; i < LH_DEPTH; i++) begin
            lhist[i] = '0;
        end
        for (int i = 0; i < LC_DEPTH; i++) begin
            lctr[i] = CTR_WEAK_LOW;
        end
        last_local  = 1'b0;
        last_global = 1'b0;
    endtask

    task automatic predict_direction(input logic [31:0] pc, output logic dir);
        int unsigned gm, lm, pm, g, l;
        gm = len_mask(cfg_glen, GLOBAL_BITS);
        lm = len_mask(cfg_llen, LOCAL_BITS);
        pm = len_mask(cfg_pclen, PC_BITS);
        case (cfg_type)
            PT_STATIC: dir = 1'b1;
            PT_GSHARE: begin
                g   = (32'(ghist) ^ pc) & gm;
                dir = gctr[g][1];
            end
            PT_TOURN: begin
                g           = 32'(ghist) & gm;
                l           = 32'(lhist[pc & pm]) & lm;
                last_local  = lctr[l][1];
                last_global = gctr[g][1];
                dir         = cctr[g][1] ? last_local : last_global;
            end
            default: dir = 1'b0;
        endcase
    endtask

    // All indexes use the histories as they stood before this transaction.
    task automatic train_direction(input logic [31:0] pc, input logic t);
        int unsigned gm, lm, pm, g, p, l;
        gm = len_mask(cfg_glen, GLOBAL_BITS);
        lm = len_mask(cfg_llen, LOCAL_BITS);
        pm = len_mask(cfg_pclen, PC_BITS);
        case (cfg_type)
            PT_GSHARE: begin
                g       = (32'(ghist) ^ pc) & gm;
                gctr[g] = sat_step(gctr[g], t);
                ghist   = GLOBAL_BITS'(((32'(ghist) << 1) | t) & gm);
            end
            PT_TOURN: begin
                g = 32'(ghist) & gm;
                if (t == last_local && t != last_global) begin
                    cctr[g] = sat_step(cctr[g], 1'b1);
                end else if (t != last_local && t == last_global) begin
                    cctr[g] = sat_step(cctr[g], 1'b0);
                end
                p        = pc & pm;
                l        = 32'(lhist[p]) & lm;
                lctr[l]  = sat_step(lctr[l], t);
                lhist[p] = LOCAL_BITS'(((32'(lhist[p]) << 1) | t) & lm);
                gctr[g]  = sat_step(gctr[g], t);
                ghist    = GLOBAL_BITS'(((32'(ghist) << 1) | t) & gm);
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic exp_v, input logic got_v);
        err_count++;
        if (err_count <= MAX_PRINTED) begin
            $display("[%0t] ERROR %s: expected %b got %b", $time, what, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic dir;
        logic exp_dir;
        if (!i_rst_n) begin
            // back to gshare with 13/10/10 bits
            cfg_type  = PT_GSHARE;
            cfg_glen  = 4'd13;
            cfg_llen  = 4'd10;
            cfg_pclen = 4'd10;
            clear_tables();
            direction_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (direction_q.size() == 0) begin
                    report("result with no request pending", 1'bx, i_predict_taken);
                end else begin
                    exp_dir = direction_q.pop_front();
                    if (i_predict_taken !== exp_dir) begin
                        report("predict_taken", exp_dir, i_predict_taken);
                    end
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_TYPE:  cfg_type  = i_cfg_wdata[1:0];
                    CFG_GLEN:  cfg_glen  = i_cfg_wdata;
                    CFG_LLEN:  cfg_llen  = i_cfg_wdata;
                    CFG_PCLEN: cfg_pclen = i_cfg_wdata;
                    default:   ;
                endcase
                clear_tables();
            end
            if (i_in_valid && i_in_ready) begin
                if (i_mode == MODE_PREDICT) begin
                    predict_direction(i_branch_pc, dir);
                    direction_q.push_back(dir);
                end else begin
                    train_direction(i_branch_pc, i_taken);
                end
            end
        end
        o_pending <= direction_q.size();
        o_errors  <= err_count;
    end

endmodule

// ----- test/branch_direction_predictor_tb.sv -----
// ----------------------------------------------------------------------------
// branch_direction_predictor_tb
// Drives prediction and training transactions through the predictor under a
// series of configurations (every type, zero, minimum, small, maximum and
// oversized lengths) with random gaps and output stalls; the checker beside
// the block predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module branch_direction_predictor_tb;
    import bdp_pkg::*;

    localparam logic [1:0] PT_UNDEF        = 2'd3;
    localparam int         N_PLAN          = 21;
    localparam int         N_RANDOM_PHASES = 4;
    localparam int         ITEMS_PER_PHASE = 47;
    localparam int         POOL            = 12;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         LONG_HOLD       = 400;
    localparam int         LIMIT_CYCLES    = 1500000;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [3:0]  cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [31:0] branch_pc;
    logic        taken;
    logic        out_valid;
    logic        out_ready;
    logic        predict_taken;
    int          pending;
    int          errors;

    int          items_sent = 0;
    int          burst_left = 0;
    bit          rx_hold    = 1'b0;
    logic [31:0] branch_pcs  [POOL];
    int          loop_period [POOL];
    int          loop_pos    [POOL];

    branch_direction_predictor u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_mode          (mode),
        .i_branch_pc     (branch_pc),
        .i_taken         (taken),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_predict_taken (predict_taken)
    );

    branch_direction_predictor_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_mode          (mode),
        .i_branch_pc     (branch_pc),
        .i_taken         (taken),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_predict_taken (predict_taken),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #(20 * LIMIT_CYCLES);
        $display("FAILURE");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (rx_hold || burst_left > 0) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Configuration sequence: {register index, write data}; past the list, random.
    function automatic logic [5:0] plan_step(input int idx);
        case (idx)
            0:       return {CFG_TYPE, 2'b00, PT_TOURN};
            1:       return {CFG_LLEN, 4'd0};
            2:       return {CFG_GLEN, 4'd15};
            3:       return {CFG_LLEN, 4'd15};
            4:       return {CFG_PCLEN, 4'd15};
            5:       return {CFG_GLEN, 4'd0};
            6:       return {CFG_PCLEN, 4'd0};
            7:       return {CFG_GLEN, 4'd1};
            8:       return {CFG_LLEN, 4'd1};
            9:       return {CFG_PCLEN, 4'd1};
            10:      return {CFG_GLEN, 4'd4};
            11:      return {CFG_LLEN, 4'd3};
            12:      return {CFG_PCLEN, 4'd2};
            13:      return {CFG_TYPE, 2'b00, PT_GSHARE};
            14:      return {CFG_GLEN, 4'd0};
            15:      return {CFG_GLEN, 4'd13};
            16:      return {CFG_TYPE, 2'b00, PT_STATIC};
            17:      return {CFG_TYPE, 2'b00, PT_UNDEF};
            18:      return {CFG_TYPE, 2'b11, PT_TOURN};  // upper data bits are dropped
            19:      return {CFG_LLEN, 4'd11};
            20:      return {CFG_PCLEN, 4'd11};
            default: return {2'($urandom_range(0, 3)), 4'($urandom_range(0, 15))};
        endcase
    endfunction

    // Hold valid and payload until the transaction is taken.
    task automatic send_item(input logic m, input logic [31:0] pc, input logic t);
        in_valid  <= 1'b1;
        mode      <= m;
        branch_pc <= pc;
        taken     <= t;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic idle_gap(input int g);
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Let the pending count catch up with the last accepted transaction first.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [3:0] data);
        cfg_addr  <= addr;
        cfg_wdata <= data;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int budget, input bit mid_pause);
        int          first;
        int          k;
        int          r;
        logic        t;
        first = items_sent;
        while (items_sent - first < budget) begin
            if (burst_left > 0) begin
                burst_left--;
            end else if ($urandom_range(0, 39) == 0) begin
                burst_left = 30;
            end
            if (mid_pause && items_sent - first >= budget / 2) begin
                mid_pause = 1'b0;
                settle();
            end
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // predict then resolve the same branch, following its loop pattern
                k = $urandom_range(0, POOL - 1);
                send_item(MODE_PREDICT, branch_pcs[k], 1'($urandom));
                idle_gap(pick_gap());
                t = (loop_pos[k] != loop_period[k] - 1) ^ ($urandom_range(0, 11) == 0);
                loop_pos[k] = (loop_pos[k] + 1) % loop_period[k];
                send_item(MODE_TRAIN, branch_pcs[k], t);
            end else if (r < 80) begin
                send_item(MODE_PREDICT, $urandom, 1'($urandom));
            end else if (r < 90) begin
                send_item(MODE_TRAIN, $urandom, 1'($urandom));
            end else begin
                k = $urandom_range(0, POOL - 1);
                send_item(MODE_TRAIN, branch_pcs[k], 1'($urandom));
            end
            idle_gap(pick_gap());
        end
    endtask

    // Output side: random stalls, one long hold-off while the sender keeps pushing.
    initial begin : receiver
        int  run_len;
        int  stall;
        int  r;
        bit  long_done;
        long_done = 1'b0;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!long_done && items_sent >= 200) begin
                long_done = 1'b1;
                rx_hold   = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                rx_hold   = 1'b0;
            end
            r = $urandom_range(0, 99);
            run_len = (r < 90) ? $urandom_range(1, 6) : $urandom_range(50, 200);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 40) stall = 0;
            else if (r < 90) stall = $urandom_range(1, 3);
            else if (r < 98) stall = $urandom_range(4, 12);
            else stall = $urandom_range(20, 60);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int         p;
        logic [5:0] step;
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_TYPE;
        cfg_wdata <= '0;
        in_valid  <= 1'b0;
        mode      <= MODE_PREDICT;
        branch_pc <= '0;
        taken     <= 1'b0;
        for (int k = 0; k < POOL; k++) begin
            // upper part of the pool shares low PC bits with the lower part
            branch_pcs[k]  = (k < 8) ? $urandom : branch_pcs[k - 8] ^ ($urandom << 11);
            loop_period[k] = $urandom_range(1, 5);
            loop_pos[k]    = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes under the reset configuration (gshare).
        send_item(MODE_PREDICT, 32'h0000_0000, 1'b0);
        send_item(MODE_PREDICT, 32'hFFFF_FFFF, 1'b1);
        send_item(MODE_TRAIN,   32'h0000_0000, 1'b1);
        send_item(MODE_TRAIN,   32'hFFFF_FFFF, 1'b0);
        send_item(MODE_PREDICT, 32'hAAAA_AAAA, 1'b0);
        send_item(MODE_PREDICT, 32'h5555_5555, 1'b1);
        send_item(MODE_PREDICT, 32'h0000_0000, 1'b1);
        for (int k = 0; k < 5; k++) begin
            send_item(MODE_TRAIN, 32'h8000_0000, 1'b1);
            send_item(MODE_PREDICT, 32'h8000_0000, 1'b0);
        end
        for (int k = 0; k < 4; k++) begin
            send_item(MODE_TRAIN, 32'h0000_0001, 1'b0);
        end
        send_item(MODE_PREDICT, 32'h0000_0001, 1'b0);
        send_item(MODE_PREDICT, 32'hFFFF_FFFE, 1'b1);

        for (p = 0; p < N_PLAN + N_RANDOM_PHASES; p++) begin
            settle();
            step = plan_step(p);
            write_reg(step[5:4], step[3:0]);
            run_phase(ITEMS_PER_PHASE, p == 2);
        end
        settle();

        if (errors == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
